[rtl/bls_pkg.sv]
// shared types and constants of the line stepper
package bls_pkg;

    localparam int COORD_BITS  = 8;
    localparam int COUNT_BITS  = COORD_BITS + 1;
    localparam int ERR_BITS    = COORD_BITS + 3;
    localparam int Q_DEPTH     = 2;
    localparam int Q_PTR_BITS  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_BITS  = $clog2(Q_DEPTH + 1);

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_STEP = 1'b1;

    typedef logic [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        logic mir_y;
        logic mir_x;
        logic swap;
    } t_flags;

    // one queued item, already classified and set up
    typedef struct packed {
        logic   is_step;
        t_coord origin_x;
        t_coord origin_y;
        t_coord major_len;
        t_coord minor_len;
        t_flags flags;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic not_empty;
    } t_q_stat;

endpackage

[rtl/bresenham_line_stepper_unit.sv]
// top level of the bresenham line stepper
// Integer Bresenham line walker for all octants. A load item (action 0) takes
// the start and end points, works out the absolute deltas, the mirror flags
// and the steep swap, and gives no result. Each step item (action 1) gives
// one pixel with is_last marking the final one; a line of major delta N gives
// exactly N pixels, the end point itself excluded, and a step on an exhausted
// or zero-length line gives nothing. Rate: one item per clock sustained, load
// or step alike. An item passes through the combinational front end into a
// two-entry queue, and its pixel appears in the output register the cycle
// after the back end takes it from the queue. The back end's single
// add-and-compare error update sets the step rate; a stalled output holds
// the back end and, once the queue is full, the input side.
module bresenham_line_stepper_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    // item input channel
    input  logic            i_valid,
    output logic            o_ready,
    input  logic            i_action,
    input  bls_pkg::t_coord i_start_x,
    input  bls_pkg::t_coord i_start_y,
    input  bls_pkg::t_coord i_end_x,
    input  bls_pkg::t_coord i_end_y,
    // pixel output channel
    output logic            o_valid,
    input  logic            i_ready,
    output bls_pkg::t_coord o_pixel_x,
    output bls_pkg::t_coord o_pixel_y,
    output logic            o_is_last
);
    import bls_pkg::*;

    t_cmd    front_cmd;
    t_cmd    q_cmd;
    t_q_stat q_stat;
    logic    q_push;
    logic    q_pop;

    // classify and set up in the front end
    bls_front u_front (
        .i_action  (i_action),
        .i_start_x (i_start_x),
        .i_start_y (i_start_y),
        .i_end_x   (i_end_x),
        .i_end_y   (i_end_y),
        .o_cmd     (front_cmd)
    );

    // input is taken whenever the queue has room
    assign o_ready = !q_stat.full;
    assign q_push  = i_valid && o_ready;

    bls_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (front_cmd),
        .i_pop       (q_pop),
        .o_pop_data  (q_cmd),
        .o_stat      (q_stat)
    );

    // walk the line and hold the pixel until taken
    bls_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_stat.not_empty),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (q_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_pixel_x   (o_pixel_x),
        .o_pixel_y   (o_pixel_y),
        .o_is_last   (o_is_last)
    );

    // an item pushed into an empty queue is visible there next cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_push && !q_stat.not_empty) |=> q_stat.not_empty)
        else $error("queue lost an item pushed while empty");

    // a new pixel only appears after a queue entry was consumed
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(q_pop))
        else $error("pixel appeared without a queued item");

    // back pressure on the input only comes from a filled queue, so never while it is empty
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> q_stat.not_empty)
        else $error("input stalled while queue is empty");

endmodule

[rtl/bls_front.sv]
// front end: classifies items and computes line setup for loads
module bls_front (
    input  logic                 i_action,
    input  bls_pkg::t_coord      i_start_x,
    input  bls_pkg::t_coord      i_start_y,
    input  bls_pkg::t_coord      i_end_x,
    input  bls_pkg::t_coord      i_end_y,
    output bls_pkg::t_cmd        o_cmd
);
    import bls_pkg::*;

    logic   neg_x;
    logic   neg_y;
    t_coord adx;
    t_coord ady;
    logic   steep;

    always_comb begin
        neg_x = i_end_x < i_start_x;
        neg_y = i_end_y < i_start_y;
        adx   = neg_x ? (i_start_x - i_end_x) : (i_end_x - i_start_x);
        ady   = neg_y ? (i_start_y - i_end_y) : (i_end_y - i_start_y);
        steep = ady > adx;

        o_cmd.is_step     = (i_action == ACT_STEP);
        o_cmd.origin_x    = i_start_x;
        o_cmd.origin_y    = i_start_y;
        o_cmd.major_len   = steep ? ady : adx;
        o_cmd.minor_len   = steep ? adx : ady;
        o_cmd.flags.swap  = steep;
        o_cmd.flags.mir_x = neg_x;
        o_cmd.flags.mir_y = neg_y;
    end

endmodule

[rtl/bls_queue.sv]
// short item queue between front and back
module bls_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  bls_pkg::t_cmd    i_push_data,
    input  logic             i_pop,
    output bls_pkg::t_cmd    o_pop_data,
    output bls_pkg::t_q_stat o_stat
);
    import bls_pkg::*;

    t_cmd                  r_mem [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] r_wr_ptr;
    logic [Q_PTR_BITS-1:0] r_rd_ptr;
    logic [Q_CNT_BITS-1:0] r_count;

    function automatic logic [Q_PTR_BITS-1:0] ptr_inc(input logic [Q_PTR_BITS-1:0] p);
        logic [Q_PTR_BITS-1:0] res;
        res = (p == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_pop_data       = r_mem[r_rd_ptr];
    assign o_stat.full      = (r_count == Q_CNT_BITS'(Q_DEPTH));
    assign o_stat.not_empty = (r_count != '0);

endmodule

[rtl/bls_back.sv]
// back end: line walk state, error update and output register
module bls_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    input  bls_pkg::t_cmd   i_cmd,
    output logic            o_cmd_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output bls_pkg::t_coord o_pixel_x,
    output bls_pkg::t_coord o_pixel_y,
    output logic            o_is_last
);
    import bls_pkg::*;

    t_coord                 r_origin_x;
    t_coord                 r_origin_y;
    t_coord                 r_major_len;
    t_coord                 r_minor_len;
    logic [COUNT_BITS-1:0]  r_major_count;
    t_coord                 r_minor_count;
    logic signed [ERR_BITS-1:0] r_err;
    t_flags                 r_flags;

    logic                   r_out_valid;
    t_coord                 r_pixel_x;
    t_coord                 r_pixel_y;
    logic                   r_is_last;

    logic                   out_free;
    logic                   pop;
    logic                   emit;
    logic                   has_pixel;
    t_coord                 off_x;
    t_coord                 off_y;
    t_coord                 n_pixel_x;
    t_coord                 n_pixel_y;
    logic                   n_is_last;
    logic signed [ERR_BITS-1:0] two_minor;
    logic signed [ERR_BITS-1:0] two_major;
    logic signed [ERR_BITS-1:0] n_err;
    logic signed [ERR_BITS-1:0] load_err;

    always_comb begin
        out_free  = !r_out_valid || i_ready;
        pop       = i_cmd_valid && out_free;
        has_pixel = r_major_count < {1'b0, r_major_len};
        emit      = pop && i_cmd.is_step && has_pixel;

        off_x = r_flags.swap ? r_minor_count : r_major_count[COORD_BITS-1:0];
        off_y = r_flags.swap ? r_major_count[COORD_BITS-1:0] : r_minor_count;
        n_pixel_x = r_flags.mir_x ? (r_origin_x - off_x) : (r_origin_x + off_x);
        n_pixel_y = r_flags.mir_y ? (r_origin_y - off_y) : (r_origin_y + off_y);
        n_is_last = (r_major_count + 1'b1) == {1'b0, r_major_len};

        two_minor = $signed({2'b00, r_minor_len, 1'b0});
        two_major = $signed({2'b00, r_major_len, 1'b0});
        n_err     = (r_err > 0) ? (r_err - two_major + two_minor) : (r_err + two_minor);

        load_err  = $signed({2'b00, i_cmd.minor_len, 1'b0})
                  - $signed({3'b000, i_cmd.major_len});
    end

    // line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x    <= '0;
            r_origin_y    <= '0;
            r_major_len   <= '0;
            r_minor_len   <= '0;
            r_major_count <= '0;
            r_minor_count <= '0;
            r_err         <= '0;
            r_flags       <= '0;
        end else if (pop && !i_cmd.is_step) begin
            r_origin_x    <= i_cmd.origin_x;
            r_origin_y    <= i_cmd.origin_y;
            r_major_len   <= i_cmd.major_len;
            r_minor_len   <= i_cmd.minor_len;
            r_major_count <= '0;
            r_minor_count <= '0;
            r_err         <= load_err;
            r_flags       <= i_cmd.flags;
        end else if (emit) begin
            r_major_count <= r_major_count + 1'b1;
            if (r_err > 0) begin
                r_minor_count <= r_minor_count + 1'b1;
            end
            r_err <= n_err;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_pixel_x <= n_pixel_x;
            r_pixel_y <= n_pixel_y;
            r_is_last <= n_is_last;
        end
    end

    assign o_cmd_pop = pop;
    assign o_valid   = r_out_valid;
    assign o_pixel_x = r_pixel_x;
    assign o_pixel_y = r_pixel_y;
    assign o_is_last = r_is_last;

endmodule
